[rtl/kmps_pkg.sv]
// Package for the killer move priority sorter: types, codes and constants.
// Holds the compare-and-swap network tables used by the sorting back end.
// No dependencies.
package kmps_pkg;

   localparam int ORDER_W = 21;
   localparam int MOVE_W  = 3;
   localparam int SCORE_W = 4;
   localparam int DEPTH_W = 6;
   localparam int SLOTS   = 7;

   localparam logic [MOVE_W-1:0]  MOVE_NONE     = 3'd7;
   localparam logic [SCORE_W-1:0] KILLER_SCORE  = 4'd10;
   localparam logic [SCORE_W-1:0] CACHED_SCORE  = 4'd11;
   localparam logic [ORDER_W-1:0] ORDER_RESET   = 21'd1754760;

   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_RECORD  = 2'd1,
      MODE_REORDER = 2'd2
   } kmps_mode_type;

   // One reorder request as it travels from the front end to the sorter.
   typedef struct packed {
      logic [MOVE_W-1:0] killer;
      logic [MOVE_W-1:0] cached;
   } kmps_job_type;

   typedef struct packed {
      logic [2:0] a;
      logic [2:0] b;
   } kmps_pair_type;

   localparam kmps_pair_type NET7 [16] = '{
      '{3'd1, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd1}, '{3'd3, 3'd4},
      '{3'd5, 3'd6}, '{3'd3, 3'd5}, '{3'd4, 3'd6}, '{3'd4, 3'd5},
      '{3'd0, 3'd4}, '{3'd0, 3'd3}, '{3'd1, 3'd5}, '{3'd2, 3'd6},
      '{3'd2, 3'd5}, '{3'd1, 3'd3}, '{3'd2, 3'd4}, '{3'd2, 3'd3}
   };

   localparam kmps_pair_type NET6 [12] = '{
      '{3'd1, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd1}, '{3'd4, 3'd5},
      '{3'd3, 3'd5}, '{3'd3, 3'd4}, '{3'd0, 3'd3}, '{3'd1, 3'd4},
      '{3'd2, 3'd5}, '{3'd2, 3'd4}, '{3'd1, 3'd3}, '{3'd2, 3'd3}
   };

   localparam kmps_pair_type NET5 [9] = '{
      '{3'd0, 3'd1}, '{3'd3, 3'd4}, '{3'd2, 3'd4}, '{3'd2, 3'd3},
      '{3'd0, 3'd3}, '{3'd0, 3'd2}, '{3'd1, 3'd4}, '{3'd1, 3'd3},
      '{3'd1, 3'd2}
   };

   function automatic int net_len(input int n);
      case (n)
         7:       net_len = 16;
         6:       net_len = 12;
         default: net_len = 9;
      endcase
   endfunction

   function automatic kmps_pair_type net_pair(input logic [2:0] n, input logic [3:0] k);
      case (n)
         3'd7:    net_pair = NET7[k];
         3'd6:    net_pair = NET6[k];
         default: net_pair = NET5[k];
      endcase
   endfunction

endpackage

[rtl/kmps_if.sv]
// Channel interfaces of the killer move priority sorter: request, response, register write.
// Depends on kmps_pkg for the field widths.
interface kmps_req_if;
   import kmps_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [DEPTH_W-1:0]  depth;
   logic [MOVE_W-1:0]   move;
   modport source (output valid, output mode, output depth, output move, input ready);
   modport sink   (input valid, input mode, input depth, input move, output ready);
endinterface

interface kmps_rsp_if;
   import kmps_pkg::*;
   logic               valid;
   logic               ready;
   logic [MOVE_W-1:0]  slot_0;
   logic [MOVE_W-1:0]  slot_1;
   logic [MOVE_W-1:0]  slot_2;
   logic [MOVE_W-1:0]  slot_3;
   logic [MOVE_W-1:0]  slot_4;
   logic [MOVE_W-1:0]  slot_5;
   logic [MOVE_W-1:0]  slot_6;
   modport source (output valid, output slot_0, output slot_1, output slot_2, output slot_3,
                   output slot_4, output slot_5, output slot_6, input ready);
   modport sink   (input valid, input slot_0, input slot_1, input slot_2, input slot_3,
                   input slot_4, input slot_5, input slot_6, output ready);
endinterface

interface kmps_csr_if;
   import kmps_pkg::*;
   logic                valid;
   logic                ready;
   logic [ORDER_W-1:0]  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/kmps_front.sv]
// Front end: accepts request beats, keeps the killer table and looks up killers.
// Depends on kmps_pkg and kmps_req_if.
module kmps_front #(
   parameter int MAX_DEPTH = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   kmps_req_if.sink              req,
   output logic                  push_valid,
   output kmps_pkg::kmps_job_type push_job,
   input  logic                  push_ready
);
   import kmps_pkg::*;

   localparam int TABLE_DEPTH = MAX_DEPTH + 1;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [7:0] MAX_D = 8'(MAX_DEPTH);

   logic [MOVE_W-1:0]       table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  vld_ff, vld_in;
   logic [MOVE_W-1:0]       rd_data_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_hit_ff;
   logic [MOVE_W-1:0]       s1_move_ff;
   logic [AW-1:0]           addr;
   logic                    in_range;
   logic                    accept;
   logic                    is_clear, is_record, is_reorder;

   assign addr      = AW'(req.depth);
   assign in_range  = ({2'b00, req.depth} <= MAX_D);
   assign req.ready = !s1_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      is_clear   = 1'b0;
      is_record  = 1'b0;
      is_reorder = 1'b0;
      unique case (req.mode)
         MODE_CLEAR:   is_clear   = 1'b1;
         MODE_RECORD:  is_record  = 1'b1;
         MODE_REORDER: is_reorder = 1'b1;
         default:      ;
      endcase
   end

   // Valid bits stand in for the table's reset value; a clear wipes them all at once.
   always_comb begin
      vld_in = vld_ff;
      if (accept && is_clear) begin
         vld_in = '0;
      end else if (accept && is_record && in_range) begin
         vld_in[addr] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = is_reorder;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         vld_ff      <= vld_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_record && in_range) begin
         table_mem[addr] <= req.move;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_reorder) begin
         rd_data_ff <= table_mem[addr];
         s1_hit_ff  <= in_range && vld_ff[addr];
         s1_move_ff <= req.move;
      end
   end

   assign push_valid      = s1_valid_ff;
   assign push_job.killer = s1_hit_ff ? rd_data_ff : MOVE_NONE;
   assign push_job.cached = s1_move_ff;

   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      accept && is_clear |=> vld_ff == '0)
      else $error("killer valid bits survive a clear");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !push_ready |=> s1_valid_ff && $stable(push_job))
      else $error("lookup stage lost its job while the queue was full");

   a_reorder_loads: assert property (@(posedge clock) disable iff (reset)
      accept && is_reorder |=> s1_valid_ff)
      else $error("accepted reorder beat did not reach the lookup stage");

endmodule

[rtl/kmps_queue.sv]
// Two-entry queue between the lookup front end and the sorting back end.
// Depends on kmps_pkg for the job type.
module kmps_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  kmps_pkg::kmps_job_type push_job,
   output logic                  push_ready,
   output logic                  pop_valid,
   output kmps_pkg::kmps_job_type pop_job,
   input  logic                  pop_ready
);
   import kmps_pkg::*;

   kmps_job_type  mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count beyond its depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count missed a push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with the count");

endmodule

[rtl/kmps_back.sv]
// Back end: scores the moves of one job, runs the sorting network, holds the response.
// Depends on kmps_pkg and kmps_rsp_if.
module kmps_back #(
   parameter int NUM_MOVES = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   input  kmps_pkg::kmps_job_type        pop_job,
   output logic                          pop_ready,
   input  logic [kmps_pkg::ORDER_W-1:0]  static_order,
   kmps_rsp_if.source                    rsp
);
   import kmps_pkg::*;

   localparam int NET_LEN = net_len(NUM_MOVES);

   logic [SCORE_W-1:0] sc [SLOTS];
   logic [MOVE_W-1:0]  mv [SLOTS];
   logic [MOVE_W-1:0]  slot_in [SLOTS];
   logic [MOVE_W-1:0]  slot_ff [SLOTS];
   logic               out_valid_ff, out_valid_in;
   logic               take;

   assign pop_ready = !out_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      logic [MOVE_W-1:0]  slot_move;
      kmps_pair_type      pr;
      logic [SCORE_W-1:0] ts;
      logic [MOVE_W-1:0]  tm;
      slot_move = '0;
      pr        = '0;
      ts        = '0;
      tm        = '0;
      for (int i = 0; i < SLOTS; i++) begin
         sc[i] = '0;
         mv[i] = MOVE_W'(i);
      end
      // Later slots win when the order names a move twice.
      for (int i = 0; i < NUM_MOVES; i++) begin
         slot_move = static_order[MOVE_W*i +: MOVE_W];
         for (int m = 0; m < NUM_MOVES; m++) begin
            if (slot_move == MOVE_W'(m)) begin
               sc[m] = SCORE_W'(NUM_MOVES - i);
            end
         end
      end
      for (int i = 0; i < NUM_MOVES; i++) begin
         if (pop_job.killer == MOVE_W'(i)) begin
            sc[i] = KILLER_SCORE;
         end
         if (pop_job.cached == MOVE_W'(i)) begin
            sc[i] = CACHED_SCORE;
         end
      end
      for (int k = 0; k < NET_LEN; k++) begin
         pr = net_pair(3'(NUM_MOVES), 4'(k));
         if (sc[pr.a] < sc[pr.b]) begin
            ts = sc[pr.a]; sc[pr.a] = sc[pr.b]; sc[pr.b] = ts;
            tm = mv[pr.a]; mv[pr.a] = mv[pr.b]; mv[pr.b] = tm;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         slot_in[i] = (i < NUM_MOVES) ? mv[i] : '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff <= slot_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.slot_0 = slot_ff[0];
   assign rsp.slot_1 = slot_ff[1];
   assign rsp.slot_2 = slot_ff[2];
   assign rsp.slot_3 = slot_ff[3];
   assign rsp.slot_4 = slot_ff[4];
   assign rsp.slot_5 = slot_ff[5];
   assign rsp.slot_6 = slot_ff[6];

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("sorted beat dropped after being taken from the queue");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |-> !take)
      else $error("queue popped into a stalled response register");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid &&
         $stable({rsp.slot_0, rsp.slot_1, rsp.slot_2, rsp.slot_3,
                  rsp.slot_4, rsp.slot_5, rsp.slot_6}))
      else $error("stalled response beat changed before it was taken");

endmodule

[rtl/killer_move_priority_sorter_top.sv]
// Top level of the killer move priority sorter: configuration register and the three parts.
// Depends on kmps_pkg, the interfaces in kmps_if, kmps_front, kmps_queue and kmps_back.
//
// Use: the search engine sends request beats on req_chan. A clear beat (mode 0) forgets
// every killer, a record beat (mode 1) stores move as the killer of its depth, and a reorder
// beat (mode 2) asks for the NUM_MOVES moves sorted by priority, with move as the cached
// move. Only a reorder beat produces a response beat on rsp_chan; slot_0 is the highest
// priority move and slots at or above NUM_MOVES read zero. Mode 3 is accepted and ignored.
// The csr_chan port writes the static order, seven 3-bit slots; it is always ready and must
// be written only while the block is idle.
// A reorder request passes the killer table read into the lookup stage, then the queue,
// then the sorting network into the response register. Throughput is one beat per cycle
// while the receiver keeps ready high; the single-port killer table read and the one-stage
// sorting network set that figure. A two-entry queue parts the front end from the sorter.
// Reset: the killer table reads as empty at once (valid bits are cleared, no sweep), the
// static order returns to slot i holding move i, and no response is pending.
// When the receiver stalls, the held response stays on rsp_chan, the queue fills, and only
// then does req_chan drop ready.
module killer_move_priority_sorter_top #(
   parameter int NUM_MOVES = 7,
   parameter int MAX_DEPTH = 63
) (
   input  logic       clock,
   input  logic       reset,
   kmps_req_if.sink   req_chan,
   kmps_rsp_if.source rsp_chan,
   kmps_csr_if.sink   csr_chan
);
   import kmps_pkg::*;

   logic [ORDER_W-1:0] order_ff, order_in;
   logic               push_valid, push_ready;
   kmps_job_type       push_job;
   logic               pop_valid, pop_ready;
   kmps_job_type       pop_job;

   // The register port never stalls.
   assign csr_chan.ready = 1'b1;
   assign order_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else begin
         order_ff <= order_in;
      end
   end

   // Front end: classifies beats, updates the killer table and reads the killer per job.
   kmps_front #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   kmps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // Back end: scoring, sorting network and the response register.
   kmps_back #(
      .NUM_MOVES (NUM_MOVES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_job      (pop_job),
      .pop_ready    (pop_ready),
      .static_order (order_ff),
      .rsp          (rsp_chan)
   );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the killer move priority sorter top level.
// Depends on kmps_pkg, the channel interfaces in kmps_if and killer_move_priority_sorter_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kmps_pkg::*;

   localparam int NUM_MOVES       = 7;
   localparam int MAX_DEPTH       = 63;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int CHUNK_ITEMS     = 170;

   // Mode 3 has no name in the package; the block accepts it and does nothing.
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   // Compare-and-swap pairs of the seven-input sorting network, in order.
   localparam int SWAP_NET [16][2] = '{
      '{1, 2}, '{0, 2}, '{0, 1}, '{3, 4}, '{5, 6}, '{3, 5}, '{4, 6}, '{4, 5},
      '{0, 4}, '{0, 3}, '{1, 5}, '{2, 6}, '{2, 5}, '{1, 3}, '{2, 4}, '{2, 3}
   };

   typedef logic [SLOTS-1:0][MOVE_W-1:0] ranking_type;

   logic clock;
   logic reset;

   kmps_req_if req_chan ();
   kmps_rsp_if rsp_chan ();
   kmps_csr_if csr_chan ();

   killer_move_priority_sorter_top #(
      .NUM_MOVES (NUM_MOVES),
      .MAX_DEPTH (MAX_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Shadow copy of the block's state, advanced as request beats are accepted.
   logic [MOVE_W-1:0]  killer_moves [MAX_DEPTH+1];
   logic [ORDER_W-1:0] order_shadow;
   ranking_type        expected_rankings [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int rsp_idle_pct   = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Scores every move and runs the sorting network, as the block does for a reorder beat.
   function automatic ranking_type rank_moves(input logic [DEPTH_W-1:0] depth,
                                              input logic [MOVE_W-1:0]  cached);
      int          score [SLOTS];
      int          mv [SLOTS];
      int          killer;
      int          named;
      int          a;
      int          b;
      int          t;
      ranking_type ranking;
      killer = (depth <= MAX_DEPTH) ? int'(killer_moves[depth]) : int'(MOVE_NONE);
      for (int i = 0; i < SLOTS; i++) begin
         score[i] = 0;
         mv[i]    = i;
      end
      // A later slot naming the same move wins; moves past the range are skipped.
      for (int i = 0; i < NUM_MOVES; i++) begin
         named = int'(order_shadow[3*i +: 3]);
         if (named < NUM_MOVES) begin
            score[named] = NUM_MOVES - i;
         end
      end
      // The cached move overrides the killer when both name the same move.
      for (int i = 0; i < NUM_MOVES; i++) begin
         if (i == killer) begin
            score[i] = KILLER_SCORE;
         end
         if (i == int'(cached)) begin
            score[i] = CACHED_SCORE;
         end
      end
      for (int k = 0; k < 16; k++) begin
         a = SWAP_NET[k][0];
         b = SWAP_NET[k][1];
         if (score[a] < score[b]) begin
            t = score[a]; score[a] = score[b]; score[b] = t;
            t = mv[a];    mv[a]    = mv[b];    mv[b]    = t;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         ranking[i] = (i < NUM_MOVES) ? mv[i][MOVE_W-1:0] : '0;
      end
      return ranking;
   endfunction

   function automatic logic [ORDER_W-1:0] random_permutation();
      int                 p [SLOTS];
      int                 j;
      int                 t;
      logic [ORDER_W-1:0] packed_order;
      for (int i = 0; i < SLOTS; i++) begin
         p[i] = i;
      end
      for (int i = SLOTS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = p[i]; p[i] = p[j]; p[j] = t;
      end
      for (int i = 0; i < SLOTS; i++) begin
         packed_order[3*i +: 3] = p[i][2:0];
      end
      return packed_order;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("MISMATCH cycle %0d: %s wanted %0d got %0d", cycle_count, what, want, got);
      mismatch_count++;
   endtask

   // Offers one request beat, with random idle cycles first, and advances the shadow state
   // once the beat is taken. Valid stays high so back-to-back beats need no gap.
   task automatic send_request(input logic [1:0]         mode,
                               input logic [DEPTH_W-1:0] depth,
                               input logic [MOVE_W-1:0]  move);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode  <= mode;
      req_chan.depth <= depth;
      req_chan.move  <= move;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (mode)
         MODE_CLEAR: begin
            foreach (killer_moves[i]) killer_moves[i] = MOVE_NONE;
         end
         MODE_RECORD: begin
            if (depth <= MAX_DEPTH) begin
               killer_moves[depth] = move;
            end
         end
         MODE_REORDER: begin
            expected_rankings.push_back(rank_moves(depth, move));
         end
         default: ;
      endcase
   endtask

   // Drops valid and waits for every pending response, with a bound.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && expected_rankings.size() != 0; n++) begin
         @(posedge clock);
      end
   endtask

   // The register may only change while the block is idle, so record and clear beats
   // still in the pipeline get a settling wait beyond the last response.
   task automatic write_static_order(input logic [ORDER_W-1:0] value);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      order_shadow = value;
   endtask

   // Mostly record-then-reorder sequences on a few hot depths so killers actually hit,
   // mixed with lone beats, ignored beats and the odd clear.
   task automatic random_burst(input int count);
      int                 sent;
      int                 pick;
      int                 reorders;
      logic [DEPTH_W-1:0] d;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         d    = $urandom_range(1) ? DEPTH_W'($urandom_range(7)) : DEPTH_W'($urandom_range(63));
         if (pick < 55) begin
            send_request(MODE_RECORD, d, MOVE_W'($urandom_range(7)));
            reorders = $urandom_range(1, 3);
            repeat (reorders) send_request(MODE_REORDER, d, MOVE_W'($urandom_range(7)));
            sent += reorders + 1;
         end else if (pick < 88) begin
            send_request(MODE_REORDER, d, MOVE_W'($urandom_range(7)));
            sent++;
         end else if (pick < 95) begin
            send_request(MODE_RECORD, d, MOVE_W'($urandom_range(7)));
            sent++;
         end else if (pick < 98) begin
            send_request(MODE_IGNORED, d, MOVE_W'($urandom_range(7)));
         end else begin
            send_request(MODE_CLEAR, d, MOVE_W'($urandom_range(7)));
            sent++;
         end
      end
   endtask

   task automatic test_directed_cases();
      // Empty killer table right after reset: plain static order, then cached extremes.
      send_request(MODE_REORDER, 6'd0,  MOVE_NONE);
      send_request(MODE_REORDER, 6'd0,  3'd0);
      send_request(MODE_REORDER, 6'd63, 3'd6);
      // Killer at the deepest entry, alone, equal to the cached move and beside it.
      send_request(MODE_RECORD,  6'd63, 3'd3);
      send_request(MODE_REORDER, 6'd63, MOVE_NONE);
      send_request(MODE_REORDER, 6'd63, 3'd3);
      send_request(MODE_REORDER, 6'd63, 3'd5);
      send_request(MODE_REORDER, 6'd62, MOVE_NONE);
      // An ignored beat must not touch the table.
      send_request(MODE_RECORD,  6'd5,  3'd4);
      send_request(MODE_IGNORED, 6'd5,  3'd1);
      send_request(MODE_REORDER, 6'd5,  MOVE_NONE);
      // Recording none erases a killer; a clear erases all of them.
      send_request(MODE_RECORD,  6'd5,  MOVE_NONE);
      send_request(MODE_REORDER, 6'd5,  3'd2);
      send_request(MODE_RECORD,  6'd0,  3'd6);
      send_request(MODE_REORDER, 6'd0,  3'd0);
      send_request(MODE_CLEAR,   6'd42, 3'd5);
      send_request(MODE_REORDER, 6'd63, MOVE_NONE);
      send_request(MODE_REORDER, 6'd0,  3'd1);
   endtask

   // Orders that are not permutations, plus the reversed and reset ones.
   task automatic test_order_extremes();
      logic [ORDER_W-1:0] orders [5];
      for (int i = 0; i < SLOTS; i++) begin
         orders[3][3*i +: 3] = 3'(SLOTS - 1 - i);
      end
      orders[0] = '0;
      orders[1] = '1;
      orders[2] = ORDER_RESET;
      orders[4] = ORDER_W'($urandom_range(2097151));
      foreach (orders[k]) begin
         write_static_order(orders[k]);
         send_request(MODE_REORDER, 6'd9, MOVE_NONE);
         send_request(MODE_RECORD,  6'd9, MOVE_W'($urandom_range(6)));
         send_request(MODE_REORDER, 6'd9, MOVE_NONE);
         send_request(MODE_REORDER, 6'd9, MOVE_W'($urandom_range(7)));
      end
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (int chunk = 0; chunk < 3; chunk++) begin
         write_static_order((chunk == 2) ? 21'($urandom_range(2097151)) : random_permutation());
         random_burst(CHUNK_ITEMS);
      end
   endtask

   // The receiver stops for a long stretch while the sender keeps offering beats, so the
   // internal queue fills and the request channel must stall.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_requests++;
      repeat (60) send_request(MODE_REORDER, DEPTH_W'($urandom_range(7)),
                               MOVE_W'($urandom_range(7)));
   endtask

   // The sender stops mid-stream until every response is back, then carries on.
   task automatic test_sender_pause();
      send_idle_pct = 12;
      rsp_idle_pct  = 46;
      random_burst(20);
      drain_responses();
      random_burst(20);
   endtask

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode  = MODE_CLEAR;
      req_chan.depth = '0;
      req_chan.move  = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      order_shadow   = ORDER_RESET;
      foreach (killer_moves[i]) killer_moves[i] = MOVE_NONE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_order_extremes();
      test_random_traffic(12, 46);
      test_random_traffic(46, 12);
      test_sender_pause();
      test_backpressure();
      test_random_traffic(0, 0);

      drain_responses();
      if (expected_rankings.size() != 0) begin
         report_mismatch("responses never returned", 0, expected_rankings.size());
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response side: checks each accepted beat against the oldest expectation and drives
   // ready, either at random or held low for a requested stretch.
   always @(posedge clock) begin : response_side
      ranking_type seen;
      ranking_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = {rsp_chan.slot_6, rsp_chan.slot_5, rsp_chan.slot_4, rsp_chan.slot_3,
                 rsp_chan.slot_2, rsp_chan.slot_1, rsp_chan.slot_0};
         if (expected_rankings.size() == 0) begin
            report_mismatch("unexpected response beat", 0, 1);
         end else begin
            want = expected_rankings.pop_front();
            for (int i = 0; i < SLOTS; i++) begin
               if (seen[i] !== want[i]) begin
                  report_mismatch($sformatf("slot_%0d", i), int'(want[i]), int'(seen[i]));
               end
            end
         end
      end
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

[sim.f]
rtl/kmps_pkg.sv
rtl/kmps_if.sv
rtl/kmps_front.sv
rtl/kmps_queue.sv
rtl/kmps_back.sv
rtl/killer_move_priority_sorter_top.sv
dv/tb_top.sv
